>>> rtl/ev_longitudinal_energy_model_top_assert.svh
// Assertion macros for the longitudinal energy model.
// Included by the RTL files that check their own logic; needs clk_i and rst_ni in scope.
`ifndef EV_LONGITUDINAL_ENERGY_MODEL_TOP_ASSERT_SVH
`define EV_LONGITUDINAL_ENERGY_MODEL_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ELM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("elm assertion failed");
`define ELM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("elm assertion failed");
`else
`define ELM_ASSERT(lbl, prop)
`define ELM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/elm_pkg.sv
// Package of the longitudinal energy model: types, constants and mode tables.
// Used by elm_core and the top level; depends on nothing.
`default_nettype none
package elm_pkg;

  localparam int unsigned ADC_BITS_DEF = 12;

  localparam int unsigned MUL_AW = 48;
  localparam int unsigned MUL_BW = 24;
  localparam int unsigned DIV_DW = 48;
  localparam int unsigned DIV_VW = 24;

  localparam logic [17:0] SPEED_MAX    = 18'd180000;
  localparam logic [17:0] SPEED_DRIVE  = 18'd500;
  localparam logic [35:0] ENERGY_MAX   = 36'd60000000000;
  localparam logic [35:0] ENERGY_RESET = 36'd48000000000;
  localparam logic [22:0] UWH_PER_SOC  = 23'd6000000;
  localparam logic [13:0] SOC_MIN_SEED = 14'd500;
  localparam logic [13:0] SOC_DEF_SEED = 14'd8000;
  localparam logic [13:0] SOC_MAX      = 14'd10000;

  localparam logic [2:0] REG_DRIVE_MODE      = 3'd0;
  localparam logic [2:0] REG_TORQUE_CUT      = 3'd1;
  localparam logic [2:0] REG_OVERRIDE_ENABLE = 3'd2;
  localparam logic [2:0] REG_OVERRIDE_SPEED  = 3'd3;
  localparam logic [2:0] REG_INITIAL_SOC     = 3'd4;

  localparam logic [1:0] MODE_ECO   = 2'd0;
  localparam logic [1:0] MODE_STD   = 2'd1;
  localparam logic [1:0] MODE_SPORT = 2'd2;

  typedef enum logic [1:0] {
    VS_PARKED = 2'd0,
    VS_DRIVE  = 2'd1,
    VS_FAULT  = 2'd2
  } vstate_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MD, ST_DD, ST_MB, ST_DB, ST_DT, ST_MV, ST_DV,
    ST_ME1, ST_ME2, ST_DE, ST_DS, ST_DR, ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic [1:0]  drive_mode;
    logic        torque_cut;
    logic        override_enable;
    logic [17:0] override_speed;
    logic        seed_we;
    logic [13:0] seed_soc;
  } cfg_t;

  // Torque scale times 25, in 0.1 Nm per full pedal.
  function automatic logic [11:0] torque_k(input logic [1:0] mode);
    logic [11:0] k;
    unique case (mode)
      MODE_ECO:   k = 12'd1625;
      MODE_SPORT: k = 12'd3375;
      default:    k = 12'd2500;
    endcase
    return k;
  endfunction

  function automatic logic [11:0] regen_k(input logic [1:0] mode);
    logic [11:0] k;
    unique case (mode)
      MODE_ECO:   k = 12'd3000;
      MODE_SPORT: k = 12'd1875;
      default:    k = 12'd2500;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

>>> rtl/elm_if.sv
// Valid/ready channel interfaces for tick samples and tick results.
// Stand-alone; used by the core and the top level.
`default_nettype none
interface elm_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] accel_sample;
  logic [11:0] brake_sample;
  logic [11:0] temp_sample;
  logic [9:0]  tick_ms;
  logic        fault_request;

  modport source(output valid, accel_sample, brake_sample, temp_sample, tick_ms,
                 fault_request, input ready);
  modport sink(input valid, accel_sample, brake_sample, temp_sample, tick_ms,
               fault_request, output ready);
endinterface

interface elm_out_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] torque_out;
  logic [17:0]        speed_out;
  logic [1:0]         vehicle_state;
  logic [13:0]        soc_out;
  logic [11:0]        range_out;
  logic [10:0]        temp_out;

  modport source(output valid, torque_out, speed_out, vehicle_state, soc_out,
                 range_out, temp_out, input ready);
  modport sink(input valid, torque_out, speed_out, vehicle_state, soc_out,
               range_out, temp_out, output ready);
endinterface
`default_nettype wire

>>> rtl/elm_mul.sv
// Shift-add multiplier that takes one multiplier bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none
module elm_mul #(
  parameter int unsigned AW = 48,
  parameter int unsigned BW = 24
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [AW-1:0] a_i,
  input  wire logic [BW-1:0] b_i,
  output logic               done_o,
  output logic [AW-1:0]      p_o
);
  localparam int unsigned CW = $clog2(BW + 1);

  logic [AW-1:0] acc_q, a_q;
  logic [BW-1:0] b_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[AW-2:0], 1'b0};
      b_q <= {1'b0, b_q[BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule
`default_nettype wire

>>> rtl/elm_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none
module elm_div #(
  parameter int unsigned DW = 48,
  parameter int unsigned VW = 24
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] n_i,
  input  wire logic [VW-1:0] d_i,
  output logic               done_o,
  output logic [DW-1:0]      q_o
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] n_q;
  logic [VW-1:0] r_q, d_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [VW:0]   r_try;
  logic          q_bit;

  assign r_try = {r_q, n_q[DW-1]};
  assign q_bit = r_try >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= n_i;
      r_q <= '0;
      d_q <= d_i;
    end else if (busy_q) begin
      r_q <= q_bit ? VW'(r_try - {1'b0, d_q}) : r_try[VW-1:0];
      n_q <= {n_q[DW-2:0], q_bit};
    end
  end

  assign done_o = done_q;
  assign q_o    = n_q;
endmodule
`default_nettype wire

>>> rtl/elm_core.sv
// Tick sequencer and state of the energy model, with the result register.
// Depends on elm_pkg, elm_if, elm_mul, elm_div and the assertion header.
`default_nettype none
`include "ev_longitudinal_energy_model_top_assert.svh"
module elm_core
  import elm_pkg::*;
#(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  elm_in_if.sink     in_if,
  elm_out_if.source  out_if
);
  localparam int unsigned FS      = (1 << ADC_BITS) - 1;
  localparam int unsigned HALF_FS = FS / 2;
  localparam logic [16:0] FS17    = 17'(FS);

  function automatic logic [11:0] sat(input logic [11:0] s);
    return ({5'd0, s} > FS17) ? FS17[11:0] : s;
  endfunction

  seq_state_e state_q, state_d;
  logic       kick_q;

  logic [11:0] a_q, b_q, t_q;
  logic [9:0]  tick_q;
  logic [11:0] drive_q, brake_q;
  logic [10:0] temp_q;
  logic        sgn_q;
  logic [17:0] speed_q;
  logic [35:0] energy_q;
  vstate_e     vs_q;
  logic [13:0] soc_q;

  logic               out_valid_q;
  logic signed [12:0] o_torque_q;
  logic [17:0]        o_speed_q;
  logic [1:0]         o_state_q;
  logic [13:0]        o_soc_q;
  logic [11:0]        o_range_q;
  logic [10:0]        o_temp_q;

  logic                mul_start, mul_done, div_start, div_done;
  logic [MUL_AW-1:0]   mul_a, mul_p;
  logic [MUL_BW-1:0]   mul_b;
  logic [DIV_DW-1:0]   div_n, div_q;
  logic [DIV_VW-1:0]   div_d;

  logic signed [21:0] num0;
  logic [20:0]        num_mag;
  logic signed [17:0] e0;
  logic [16:0]        e_mag;
  logic signed [19:0] speed_new;
  logic signed [37:0] energy_new;
  logic [13:0]        seed_soc;
  logic               accept, emit;

  assign accept = in_if.valid && in_if.ready;
  assign emit   = (state_q == ST_DONE) && (!out_valid_q || out_if.ready);

  assign num0 = $signed(22'(drive_q) * 22'd180) - $signed(22'(brake_q) * 22'd280)
              - $signed(22'(speed_q) * 22'd3);
  assign num_mag = num0[21] ? 21'(-num0) : num0[20:0];
  assign e0 = $signed(18'(brake_q) * 18'd9) - 18'sd15000 - $signed(18'(drive_q) * 18'd14);
  assign e_mag = e0[17] ? 17'(-e0) : e0[16:0];

  assign speed_new = sgn_q ? $signed({2'b0, speed_q}) - $signed({5'b0, div_q[14:0]})
                           : $signed({2'b0, speed_q}) + $signed({5'b0, div_q[14:0]});
  assign energy_new = sgn_q ? $signed({2'b0, energy_q}) - $signed({13'b0, div_q[24:0]})
                            : $signed({2'b0, energy_q}) + $signed({13'b0, div_q[24:0]});

  assign seed_soc = (cfg_i.seed_soc < SOC_MIN_SEED) ? SOC_DEF_SEED :
                    (cfg_i.seed_soc > SOC_MAX) ? SOC_MAX : cfg_i.seed_soc;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MD:   begin mul_a = MUL_AW'(a_q);     mul_b = MUL_BW'(torque_k(cfg_i.drive_mode)); end
      ST_MB:   begin mul_a = MUL_AW'(b_q);     mul_b = MUL_BW'(regen_k(cfg_i.drive_mode));  end
      ST_MV:   begin mul_a = MUL_AW'(num_mag); mul_b = MUL_BW'(tick_q);  end
      ST_ME1:  begin mul_a = MUL_AW'(e_mag);   mul_b = MUL_BW'(speed_q); end
      ST_ME2:  begin mul_a = mul_p;            mul_b = MUL_BW'(tick_q);  end
      default: begin mul_a = '0;               mul_b = '0;               end
    endcase
  end

  always_comb begin
    div_n = '0;
    div_d = '0;
    unique case (state_q)
      ST_DD, ST_DB: begin
        div_n = mul_p + DIV_DW'(HALF_FS);
        div_d = DIV_VW'(FS);
      end
      ST_DT: begin
        div_n = DIV_DW'(t_q) * DIV_DW'(1200) + DIV_DW'(HALF_FS);
        div_d = DIV_VW'(FS);
      end
      ST_DV: begin
        div_n = mul_p + DIV_DW'(25000);
        div_d = DIV_VW'(50000);
      end
      ST_DE: begin
        div_n = mul_p + DIV_DW'(180000);
        div_d = DIV_VW'(360000);
      end
      ST_DS: begin
        div_n = DIV_DW'(energy_q) + DIV_DW'(UWH_PER_SOC >> 1);
        div_d = DIV_VW'(UWH_PER_SOC);
      end
      ST_DR: begin
        div_n = DIV_DW'({soc_q, 1'b0}) + DIV_DW'(2);
        div_d = DIV_VW'(5);
      end
      default: begin
        div_n = '0;
        div_d = '0;
      end
    endcase
  end

  assign mul_start = kick_q && (state_q == ST_MD || state_q == ST_MB ||
                     (state_q == ST_MV && !cfg_i.override_enable) ||
                     state_q == ST_ME1 || state_q == ST_ME2);
  assign div_start = kick_q && (state_q == ST_DD || state_q == ST_DB || state_q == ST_DT ||
                     state_q == ST_DV || state_q == ST_DE || state_q == ST_DS ||
                     state_q == ST_DR);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_MD;
      ST_MD:   if (mul_done) state_d = ST_DD;
      ST_DD:   if (div_done) state_d = ST_MB;
      ST_MB:   if (mul_done) state_d = ST_DB;
      ST_DB:   if (div_done) state_d = ST_DT;
      ST_DT:   if (div_done) state_d = ST_MV;
      ST_MV: begin
        if (cfg_i.override_enable && kick_q) begin
          state_d = ST_ME1;
        end else if (mul_done) begin
          state_d = ST_DV;
        end
      end
      ST_DV:   if (div_done) state_d = ST_ME1;
      ST_ME1:  if (mul_done) state_d = ST_ME2;
      ST_ME2:  if (mul_done) state_d = ST_DE;
      ST_DE:   if (div_done) state_d = ST_DS;
      ST_DS:   if (div_done) state_d = ST_DR;
      ST_DR:   if (div_done) state_d = ST_DONE;
      ST_DONE: if (emit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kick_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      kick_q  <= state_d != state_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= '0;
      energy_q    <= ENERGY_RESET;
      vs_q        <= VS_PARKED;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.seed_we) begin
        energy_q <= 36'(seed_soc) * 36'(UWH_PER_SOC);
      end
      if (accept && in_if.fault_request) begin
        vs_q <= VS_FAULT;
      end
      if (state_q == ST_MV && kick_q && cfg_i.override_enable) begin
        speed_q <= (cfg_i.override_speed > SPEED_MAX) ? SPEED_MAX : cfg_i.override_speed;
      end
      if (state_q == ST_DV && div_done) begin
        if (speed_new < 0) begin
          speed_q <= '0;
        end else if (speed_new > $signed({2'b0, SPEED_MAX})) begin
          speed_q <= SPEED_MAX;
        end else begin
          speed_q <= speed_new[17:0];
        end
      end
      if (state_q == ST_ME1 && kick_q) begin
        if (speed_q > SPEED_DRIVE) begin
          vs_q <= VS_DRIVE;
        end else if (vs_q != VS_FAULT) begin
          vs_q <= VS_PARKED;
        end
      end
      if (state_q == ST_DE && div_done) begin
        if (energy_new < 0) begin
          energy_q <= '0;
        end else if (energy_new > $signed({2'b0, ENERGY_MAX})) begin
          energy_q <= ENERGY_MAX;
        end else begin
          energy_q <= energy_new[35:0];
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q    <= (in_if.fault_request || vs_q == VS_FAULT) ? 12'd0 : sat(in_if.accel_sample);
      b_q    <= sat(in_if.brake_sample);
      t_q    <= sat(in_if.temp_sample);
      tick_q <= in_if.tick_ms;
    end
    if (state_q == ST_DD && div_done) begin
      drive_q <= cfg_i.torque_cut ? 12'd0 : div_q[11:0];
    end
    if (state_q == ST_DB && div_done) begin
      brake_q <= div_q[11:0];
    end
    if (state_q == ST_DT && div_done) begin
      temp_q <= div_q[10:0];
    end
    if (state_q == ST_MV && kick_q) begin
      sgn_q <= num0[21];
    end
    if (state_q == ST_ME1 && kick_q) begin
      sgn_q <= e0[17];
    end
    if (state_q == ST_DS && div_done) begin
      soc_q <= div_q[13:0];
    end
    if (emit) begin
      o_range_q  <= div_q[11:0];
      o_torque_q <= $signed(13'({1'b0, drive_q}) - 13'({1'b0, brake_q}));
      o_speed_q  <= speed_q;
      o_state_q  <= vs_q;
      o_soc_q    <= soc_q;
      o_temp_q   <= temp_q;
    end
  end

  elm_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  elm_div #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .n_i    (div_n),
    .d_i    (div_d),
    .done_o (div_done),
    .q_o    (div_q)
  );

  assign in_if.ready          = state_q == ST_IDLE;
  assign out_if.valid         = out_valid_q;
  assign out_if.torque_out    = o_torque_q;
  assign out_if.speed_out     = o_speed_q;
  assign out_if.vehicle_state = o_state_q;
  assign out_if.soc_out       = o_soc_q;
  assign out_if.range_out     = o_range_q;
  assign out_if.temp_out      = o_temp_q;

  `ELM_ASSERT(a_accept_busy, accept |=> !in_if.ready)
  `ELM_ASSERT(a_speed_max, speed_q <= SPEED_MAX)
  `ELM_ASSERT_ALWAYS(a_energy_max, energy_q <= ENERGY_MAX)
  `ELM_ASSERT(a_units_exclusive, !(mul_start && div_start))
endmodule
`default_nettype wire

>>> rtl/ev_longitudinal_energy_model_top.sv
// Channel   Dir  Handshake      Payload
// in_if     in   valid/ready    accel, brake, temp samples, tick_ms, fault_request
// out_if    out  valid/ready    torque, speed, state, soc, range, temp
// apb       in   psel/penable   drive_mode, torque_cut, override, initial_soc
// A tick runs five 24-step multiplies on one shift-add multiplier and seven 48-step
// divides on one restoring divider; the speed override skips the speed multiply and divide.
// A new tick is taken once the previous one has left the sequencer, while its result
// still waits in the output register. Reset seeds the pack energy at 80 percent SOC;
// writing initial_soc reseeds it at once.
// Top level: APB register file around the core. Depends on elm_pkg, elm_if and elm_core.
`default_nettype none
module ev_longitudinal_energy_model_top
  import elm_pkg::*;
#(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  elm_in_if.sink           in_if,
  elm_out_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [1:0]  drive_mode_q;
  logic        torque_cut_q, override_enable_q;
  logic [17:0] override_speed_q;
  logic [13:0] initial_soc_q;
  logic        wr;
  logic [2:0]  idx;
  cfg_t        cfg;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_mode_q      <= MODE_STD;
      torque_cut_q      <= 1'b0;
      override_enable_q <= 1'b0;
      override_speed_q  <= '0;
      initial_soc_q     <= SOC_DEF_SEED;
    end else if (wr) begin
      unique case (idx)
        REG_DRIVE_MODE:      drive_mode_q      <= pwdata[1:0];
        REG_TORQUE_CUT:      torque_cut_q      <= pwdata[0];
        REG_OVERRIDE_ENABLE: override_enable_q <= pwdata[0];
        REG_OVERRIDE_SPEED:  override_speed_q  <= pwdata[17:0];
        REG_INITIAL_SOC:     initial_soc_q     <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DRIVE_MODE:      prdata = 32'(drive_mode_q);
      REG_TORQUE_CUT:      prdata = 32'(torque_cut_q);
      REG_OVERRIDE_ENABLE: prdata = 32'(override_enable_q);
      REG_OVERRIDE_SPEED:  prdata = 32'(override_speed_q);
      REG_INITIAL_SOC:     prdata = 32'(initial_soc_q);
      default:             prdata = '0;
    endcase
  end

  assign cfg.drive_mode      = drive_mode_q;
  assign cfg.torque_cut      = torque_cut_q;
  assign cfg.override_enable = override_enable_q;
  assign cfg.override_speed  = override_speed_q;
  assign cfg.seed_we         = wr && (idx == REG_INITIAL_SOC);
  assign cfg.seed_soc        = pwdata[13:0];

  elm_core #(.ADC_BITS(ADC_BITS)) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .in_if (in_if),
    .out_if(out_if)
  );
endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Testbench for ev_longitudinal_energy_model_top: random and directed ticks with a
// self-checking predictor of torque, speed, state, SOC, range and temperature.
// Depends on elm_pkg, elm_if and the RTL of the block.
`timescale 1ns / 100ps
module tb_top;
  import elm_pkg::*;

  typedef struct {
    logic [11:0] accel;
    logic [11:0] brake;
    logic [11:0] temp;
    logic [9:0]  tick;
    logic        fault;
  } tick_t;

  typedef struct {
    logic signed [12:0] torque;
    logic [17:0]        speed;
    logic [1:0]         vst;
    logic [13:0]        soc;
    logic [11:0]        range;
    logic [10:0]        temp;
  } report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  elm_in_if  in_if();
  elm_out_if out_if();

  ev_longitudinal_energy_model_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tick_t   ticks_pending[$];
  report_t reports_due[$];
  tick_t   cur_tick;
  int      errors;
  int      reports_seen;
  int      faults_sent;
  bit      calm;
  int      hold_len;
  int      hold_cnt;

  // Predictor copy of the configuration and state.
  logic [1:0]  mode_r;
  logic        cut_r;
  logic        ovr_en_r;
  logic [17:0] ovr_speed_r;
  logic [13:0] soc_seed_r;
  longint      speed_m;
  longint      energy_m;
  vstate_e     vst_m;

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic void reseed_energy();
    longint s;
    s = soc_seed_r;
    if (s < 500) s = 8000;
    if (s > 10000) s = 10000;
    energy_m = s * 6000000;
  endfunction

  function automatic report_t step_vehicle(tick_t it);
    report_t r;
    longint  a, drv, brk, tk, soc;
    longint  tq, rg;
    if (it.fault) vst_m = VS_FAULT;
    a = (vst_m == VS_FAULT) ? 0 : it.accel;
    case (mode_r)
      MODE_ECO:   begin tq = 65;  rg = 120; end
      MODE_SPORT: begin tq = 135; rg = 75;  end
      default:    begin tq = 100; rg = 100; end
    endcase
    drv = (a * 25 * tq + 2047) / 4095;
    brk = (longint'(it.brake) * 25 * rg + 2047) / 4095;
    if (cut_r) drv = 0;
    tk = it.tick;
    if (!ovr_en_r) begin
      speed_m += round_div((180 * drv - 280 * brk - 3 * speed_m) * tk, 50000);
      if (speed_m < 0) speed_m = 0;
      if (speed_m > 180000) speed_m = 180000;
    end else begin
      speed_m = (ovr_speed_r > 180000) ? 180000 : ovr_speed_r;
    end
    if (speed_m > 500) vst_m = VS_DRIVE;
    else if (vst_m != VS_FAULT) vst_m = VS_PARKED;
    energy_m += round_div((9 * brk - 15000 - 14 * drv) * speed_m * tk, 360000);
    if (energy_m < 0) energy_m = 0;
    if (energy_m > 64'd60000000000) energy_m = 64'd60000000000;
    soc = (energy_m + 3000000) / 6000000;
    r.torque = 13'(drv - brk);
    r.speed  = 18'(speed_m);
    r.vst    = vst_m;
    r.soc    = 14'(soc);
    r.range  = 12'((soc * 2 + 2) / 5);
    r.temp   = 11'((longint'(it.temp) * 1200 + 2047) / 4095);
    return r;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #60000000;
    $display("Timeout with %0d results still due.", reports_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Sender: one pending tick is offered per transfer, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        reports_due.push_back(step_vehicle(cur_tick));
        if (cur_tick.fault) faults_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (ticks_pending.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
          cur_tick = ticks_pending.pop_front();
          in_if.valid         <= 1'b1;
          in_if.accel_sample  <= cur_tick.accel;
          in_if.brake_sample  <= cur_tick.brake;
          in_if.temp_sample   <= cur_tick.temp;
          in_if.tick_ms       <= cur_tick.tick;
          in_if.fault_request <= cur_tick.fault;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt > 0) begin
      out_if.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_len > 0) begin
      out_if.ready <= 1'b0;
      hold_cnt <= hold_len;
      hold_len <= 0;
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk_i) begin
    report_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      reports_seen++;
      if (reports_due.size() == 0) begin
        errors++;
        $display("%0t: result transfer with no expected result, speed %0d", $time,
                 out_if.speed_out);
      end else begin
        e = reports_due.pop_front();
        check_field("torque_out", e.torque, out_if.torque_out);
        check_field("speed_out", e.speed, out_if.speed_out);
        check_field("vehicle_state", e.vst, out_if.vehicle_state);
        check_field("soc_out", e.soc, out_if.soc_out);
        check_field("range_out", e.range, out_if.range_out);
        check_field("temp_out", e.temp, out_if.temp_out);
      end
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DRIVE_MODE:      mode_r = val[1:0];
      REG_TORQUE_CUT:      cut_r = val[0];
      REG_OVERRIDE_ENABLE: ovr_en_r = val[0];
      REG_OVERRIDE_SPEED:  ovr_speed_r = val[17:0];
      REG_INITIAL_SOC:     begin soc_seed_r = val[13:0]; reseed_energy(); end
      default: ;
    endcase
  endtask

  task automatic configure(int md, int cut, int oen, int ospd, int soc);
    apb_write(REG_DRIVE_MODE, md);
    apb_write(REG_TORQUE_CUT, cut);
    apb_write(REG_OVERRIDE_ENABLE, oen);
    apb_write(REG_OVERRIDE_SPEED, ospd);
    apb_write(REG_INITIAL_SOC, soc);
  endtask

  task automatic add_tick(int a, int b, int t, int tk, int f);
    tick_t it;
    it.accel = a;
    it.brake = b;
    it.temp  = t;
    it.tick  = tk;
    it.fault = f;
    ticks_pending.push_back(it);
  endtask

  // Drive-cycle segments: accelerate, brake, coast, or fully random noise.
  task automatic add_drive_cycle(int n);
    int seg, left, pick, tk;
    seg  = 0;
    left = 0;
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        seg  = $urandom_range(3);
        left = $urandom_range(4, 30);
      end
      left--;
      pick = $urandom_range(99);
      tk = (pick < 5) ? 0 : (pick < 10) ? $urandom_range(1001, 1023) : $urandom_range(1, 1000);
      case (seg)
        0: add_tick($urandom_range(2000, 4095), 0, $urandom_range(4095), tk,
                    $urandom_range(99) < 2);
        1: add_tick(0, $urandom_range(4095), $urandom_range(4095), tk,
                    $urandom_range(99) < 2);
        2: add_tick($urandom_range(200), $urandom_range(200), $urandom_range(4095), tk,
                    $urandom_range(99) < 2);
        default: add_tick($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                          $urandom_range(1023), $urandom_range(1));
      endcase
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    wait (ticks_pending.size() == 0 && !in_if.valid && reports_due.size() == 0);
    repeat (520) @(posedge clk_i);
  endtask

  initial begin
    errors = 0;
    reports_seen = 0;
    faults_sent = 0;
    calm = 1'b0;
    hold_len = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.accel_sample = '0;
    in_if.brake_sample = '0;
    in_if.temp_sample = '0;
    in_if.tick_ms = '0;
    in_if.fault_request = 1'b0;
    out_if.ready = 1'b0;
    mode_r = MODE_STD;
    cut_r = 1'b0;
    ovr_en_r = 1'b0;
    ovr_speed_r = '0;
    soc_seed_r = SOC_DEF_SEED;
    speed_m = 0;
    vst_m = VS_PARKED;
    reseed_energy();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    add_tick(0, 0, 0, 0, 0);
    repeat (4) add_tick(4095, 0, 4095, 1000, 0);
    add_tick(4095, 0, 0, 1023, 0);
    add_tick(0, 4095, 2048, 1000, 0);
    add_tick(0, 0, 4095, 0, 0);
    add_tick(4095, 4095, 1, 500, 0);
    add_tick(4095, 0, 100, 1000, 1);
    add_tick(4095, 0, 100, 1000, 0);
    repeat (3) add_tick(0, 4095, 3000, 1000, 0);
    add_tick(0, 0, 0, 1000, 0);
    add_tick(4095, 0, 0, 1, 0);
    add_tick(2048, 2048, 2048, 512, 0);
    add_tick(1, 1, 1, 1, 0);
    add_tick(4094, 4094, 4094, 1022, 1);
    drain();

    calm = 1'b1;
    configure(MODE_ECO, 0, 0, 0, 10000);
    @(negedge clk_i);
    add_drive_cycle(313);
    drain();
    calm = 1'b0;

    configure(MODE_SPORT, 1, 1, 180000, 10000);
    @(negedge clk_i);
    add_drive_cycle(313);
    drain();

    configure(3, 0, 1, 18'h3FFFF, 500);
    @(negedge clk_i);
    add_drive_cycle(313);
    drain();

    configure(MODE_SPORT, 0, 0, 1, 499);
    @(negedge clk_i);
    add_drive_cycle(313);
    hold_len = 3000;
    drain();

    configure(MODE_STD, 1, 0, 0, 14'h3FFF);
    @(negedge clk_i);
    add_drive_cycle(313);
    drain();

    configure(MODE_ECO, 0, 0, 90000, 0);
    @(negedge clk_i);
    add_drive_cycle(313);
    drain();

    $display("Checked %0d tick results (%0d with fault request) over seven settings,",
             reports_seen, faults_sent);
    $display("covering all drive modes, torque cut, speed override and SOC seed limits.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/elm_pkg.sv
rtl/elm_if.sv
rtl/elm_mul.sv
rtl/elm_div.sv
rtl/elm_core.sv
rtl/ev_longitudinal_energy_model_top.sv
bench/tb_top.sv
